@@ sv/enigma_rotor_stage_assert.svh @@
// ----------------------------------------------------------------------------
// enigma_rotor_stage assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ENIGMA_ROTOR_STAGE_ASSERT_SVH
`define ENIGMA_ROTOR_STAGE_ASSERT_SVH

`ifndef SYNTHESIS
// check under reset qualification
`define ERS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("enigma_rotor_stage check failed");
// check on the raw clock, reset included
`define ERS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("enigma_rotor_stage check failed");
`else
`define ERS_ASSERT(label, clk, rst_n, prop)
`define ERS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ sv/enr_pkg.sv @@
// ----------------------------------------------------------------------------
// enr_pkg
// Shared types, constants and the small modulo helper of the rotor stage.
// ----------------------------------------------------------------------------
package enr_pkg;

    localparam int LETTER_W = 5;
    localparam int SUM_W    = LETTER_W + 1;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ROTATE = 2'd1,
        OP_FWD    = 2'd2,
        OP_BWD    = 2'd3
    } t_op;

    // one port set of a wiring memory
    typedef struct packed {
        logic                we;
        logic [LETTER_W-1:0] waddr;
        logic [LETTER_W-1:0] wdata;
        logic                re;
        logic [LETTER_W-1:0] raddr;
    } t_ram_req;

    // item in flight between lookup issue and result
    typedef struct packed {
        logic                is_pass;
        logic                is_bwd;
        logic [LETTER_W-1:0] offset;
        logic                hit;
    } t_s1;

    // v mod n for v < 64, n in 2..32: restoring reduction, six compare/subtract steps
    function automatic logic [SUM_W-1:0] mod_fold(input logic [SUM_W-1:0] v,
                                                  input logic [SUM_W-1:0] n);
        logic [2*SUM_W-1:0] acc;
        logic [2*SUM_W-1:0] step;
        acc = {{SUM_W{1'b0}}, v};
        for (int k = SUM_W - 1; k >= 0; k--) begin
            step = {{SUM_W{1'b0}}, n} << k;
            if (acc >= step) begin
                acc = acc - step;
            end
        end
        return acc[SUM_W-1:0];
    endfunction

endpackage

@@ sv/enigma_rotor_stage.sv @@
// ----------------------------------------------------------------------------
// enigma_rotor_stage
// One cipher rotor: wiring load, stepping with notch report, forward and
// backward passes through two wiring RAMs.
// ----------------------------------------------------------------------------
// Takes one item per cycle while not stalled. Each accepted item passes the
// wiring RAM read (one registered read port per map), then the result
// register. A load writes both maps at its acceptance edge, so a pass right
// behind it already sees the new entry. Input stalls only while the result
// register is full and stalled. The notch register may be written at any time
// the block is idle; offset resets to zero, wiring is undefined until loaded.
// ----------------------------------------------------------------------------
`include "enigma_rotor_stage_assert.svh"

module enigma_rotor_stage import enr_pkg::*; #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [LETTER_W-1:0] i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_operation,
    input  logic [LETTER_W-1:0] i_entry_index,
    input  logic [LETTER_W-1:0] i_letter,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [LETTER_W-1:0] o_letter_out,
    output logic                o_notch_hit
);

    localparam int AW = $clog2(ALPHABET_SIZE);

    t_ram_req            fwd_req;
    t_ram_req            inv_req;
    logic [LETTER_W-1:0] fwd_rdata;
    logic [LETTER_W-1:0] inv_rdata;
    logic                s1_vld;
    t_s1                 s1;
    logic                adv;

    enr_issue #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_issue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_entry_index (i_entry_index),
        .i_letter      (i_letter),
        .i_adv         (adv),
        .o_fwd_req     (fwd_req),
        .o_inv_req     (inv_req),
        .o_s1_vld      (s1_vld),
        .o_s1          (s1)
    );

    enr_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (fwd_req.we),
        .i_waddr (fwd_req.waddr[AW-1:0]),
        .i_wdata (fwd_req.wdata),
        .i_re    (fwd_req.re),
        .i_raddr (fwd_req.raddr[AW-1:0]),
        .o_rdata (fwd_rdata)
    );

    enr_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_inv_ram (
        .i_clk   (i_clk),
        .i_we    (inv_req.we),
        .i_waddr (inv_req.waddr[AW-1:0]),
        .i_wdata (inv_req.wdata),
        .i_re    (inv_req.re),
        .i_raddr (inv_req.raddr[AW-1:0]),
        .o_rdata (inv_rdata)
    );

    enr_retire #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_retire (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1_vld     (s1_vld),
        .i_s1         (s1),
        .i_fwd_rdata  (fwd_rdata),
        .i_inv_rdata  (inv_rdata),
        .o_adv        (adv),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_letter_out (o_letter_out),
        .o_notch_hit  (o_notch_hit)
    );

    // input only backs up when the result register is full and held
    `ERS_ASSERT(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> (o_out_valid && i_out_stall))
    // a notch report never carries a letter
    `ERS_ASSERT(a_hit_no_letter, i_clk, i_rst_n, (o_out_valid && o_notch_hit) |-> (o_letter_out == '0))
    // both wiring maps are never read by the same item
    `ERS_ASSERT_ALWAYS(a_one_lookup, i_clk, !(fwd_req.re && inv_req.re))

endmodule

@@ sv/enr_ram.sv @@
// ----------------------------------------------------------------------------
// enr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module enr_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 26
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/enr_issue.sv @@
// ----------------------------------------------------------------------------
// enr_issue
// Input stage: offset and notch registers, wiring writes and lookup reads.
// ----------------------------------------------------------------------------
module enr_issue import enr_pkg::*; #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [LETTER_W-1:0] i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_operation,
    input  logic [LETTER_W-1:0] i_entry_index,
    input  logic [LETTER_W-1:0] i_letter,
    input  logic                i_adv,
    output t_ram_req            o_fwd_req,
    output t_ram_req            o_inv_req,
    output logic                o_s1_vld,
    output t_s1                 o_s1
);

    localparam logic [SUM_W-1:0] N_SZ = SUM_W'(ALPHABET_SIZE);

    logic [LETTER_W-1:0] r_offset, n_offset;
    logic [LETTER_W-1:0] r_notch;
    logic                r_s1_vld, n_s1_vld;
    t_s1                 r_s1, n_s1;

    logic                accept;
    t_op                 op;
    logic [SUM_W-1:0]    step_sum;
    logic [SUM_W-1:0]    pos;
    logic                load_ok;

    assign op         = t_op'(i_operation);
    assign o_in_stall = r_s1_vld && !i_adv;
    assign accept     = i_in_valid && !o_in_stall;

    assign step_sum = {1'b0, r_offset} + SUM_W'(1);
    assign pos      = mod_fold({1'b0, i_letter} + {1'b0, r_offset}, N_SZ);
    assign load_ok  = ({1'b0, i_entry_index} < N_SZ) && ({1'b0, i_letter} < N_SZ);

    always_comb begin
        n_offset = r_offset;
        n_s1     = '0;
        o_fwd_req = '0;
        o_inv_req = '0;
        o_fwd_req.waddr = i_entry_index;
        o_fwd_req.wdata = i_letter;
        o_fwd_req.raddr = pos[LETTER_W-1:0];
        o_inv_req.waddr = i_letter;
        o_inv_req.wdata = i_entry_index;
        o_inv_req.raddr = pos[LETTER_W-1:0];
        n_s1.offset = r_offset;
        unique case (op)
            OP_LOAD: begin
                o_fwd_req.we = accept && load_ok;
                o_inv_req.we = accept && load_ok;
            end
            OP_ROTATE: begin
                n_offset = (step_sum == N_SZ) ? '0 : step_sum[LETTER_W-1:0];
                n_s1.hit = (n_offset == r_notch);
            end
            OP_FWD: begin
                o_fwd_req.re = accept;
                n_s1.is_pass = 1'b1;
            end
            OP_BWD: begin
                o_inv_req.re = accept;
                n_s1.is_pass = 1'b1;
                n_s1.is_bwd  = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_s1_vld = r_s1_vld;
        if (accept) begin
            n_s1_vld = 1'b1;
        end else if (i_adv) begin
            n_s1_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_notch  <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            if (accept) begin
                r_offset <= n_offset;
            end
            if (i_cfg_wr_en) begin
                r_notch <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_vld = r_s1_vld;
    assign o_s1     = r_s1;

endmodule

@@ sv/enr_retire.sv @@
// ----------------------------------------------------------------------------
// enr_retire
// Result stage: removes the offset from the looked-up letter, holds the result.
// ----------------------------------------------------------------------------
module enr_retire import enr_pkg::*; #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s1_vld,
    input  t_s1                 i_s1,
    input  logic [LETTER_W-1:0] i_fwd_rdata,
    input  logic [LETTER_W-1:0] i_inv_rdata,
    output logic                o_adv,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [LETTER_W-1:0] o_letter_out,
    output logic                o_notch_hit
);

    localparam logic [SUM_W-1:0] N_SZ = SUM_W'(ALPHABET_SIZE);

    logic                r_out_vld, n_out_vld;
    logic [LETTER_W-1:0] r_letter, n_letter;
    logic                r_hit, n_hit;

    logic [LETTER_W-1:0] wired;
    logic [SUM_W-1:0]    unshift;
    logic [SUM_W-1:0]    folded;

    assign o_adv = !r_out_vld || !i_out_stall;

    assign wired   = i_s1.is_bwd ? i_inv_rdata : i_fwd_rdata;
    // wired + N - offset stays below 64, so one fold covers the raw entry too
    assign unshift = {1'b0, wired} + N_SZ - {1'b0, i_s1.offset};
    assign folded  = mod_fold(unshift, N_SZ);

    always_comb begin
        n_out_vld = r_out_vld;
        n_letter  = i_s1.is_pass ? folded[LETTER_W-1:0] : '0;
        n_hit     = i_s1.hit;
        if (i_s1_vld && o_adv) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s1_vld && o_adv) begin
            r_letter <= n_letter;
            r_hit    <= n_hit;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_letter_out = r_letter;
    assign o_notch_hit  = r_hit;

endmodule
